/* hdl/assert_macros.svh */
// assertion helpers for the rtl files, included by shd_sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is high
`define SHD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising edge, including reset cycles
`define SHD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/shd_pkg.sv */
`default_nettype none

package shd_pkg;

   localparam int RAW_BITS   = 3;
   localparam int AXIS_BITS  = 2;
   localparam int AXIS_SLOTS = 4;
   localparam int CFG_BITS   = 16;
   localparam int CSR_ADDR_BITS = 2;

   localparam int DEF_HISTORY_BITS = 8;
   localparam int DEF_NUM_SWITCHES = 3;

   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 16;

   localparam logic [CFG_BITS-1:0] RST_DEBOUNCE_PERIOD = 16'd1000;
   localparam logic [CFG_BITS-1:0] RST_FAST_DELAY      = 16'd500;
   localparam logic [CFG_BITS-1:0] RST_SLOW_DELAY      = 16'd2000;
   localparam logic [CFG_BITS-1:0] RST_BACKOFF_STEPS   = 16'd200;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_DEBOUNCE_PERIOD = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_FAST_DELAY      = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SLOW_DELAY      = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_BACKOFF_STEPS   = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_FAST    = 2'd1,
      PH_BACKOFF = 2'd2,
      PH_CREEP   = 2'd3
   } phase_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] debounce_period;
      logic [CFG_BITS-1:0] fast_delay;
      logic [CFG_BITS-1:0] slow_delay;
      logic [CFG_BITS-1:0] backoff_steps;
   } cfg_type;

   typedef struct packed {
      logic                 home_done;
      phase_type            phase;
      logic [AXIS_BITS-1:0] active_axis;
      logic                 driver_enable;
      logic                 direction;
      logic                 step_pulse;
   } seq_out_type;

endpackage

`default_nettype wire

/* hdl/stepper_homing_with_switch_debounce_unit.sv */
`default_nettype none

// channel   direction  handshake              payload
// req       in         req_tvalid/req_tready  req_tdata[7:0]: one time tick
// rsp       out        rsp_tvalid/rsp_tready  rsp_tdata[15:0]: one result per tick
// csr       in         csr_we                 csr_addr, csr_wdata (write only)
//
// one item per clock while rsp is not stalled; each item passes an input
// register and then a result register, where its result becomes valid
// the tick logic (divider, debounce, phase sequencer) sits between those two
// registers and updates all state in the same cycle the item moves on
// synchronous active-high reset restores register defaults and idle phase
// while rsp is stalled the input register holds one more item, then req stalls

module stepper_homing_with_switch_debounce_unit #(
   parameter int HISTORY_BITS = shd_pkg::DEF_HISTORY_BITS,
   parameter int NUM_SWITCHES = shd_pkg::DEF_NUM_SWITCHES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // raw_switches[2:0], start_req[3], axis[5:4], home_dir[6], zero[7]
   input  wire logic [shd_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // step_pulse[0], direction[1], driver_enable[2], active_axis[4:3],
   // phase[6:5], home_done[7], switch_states[10:8], zero[15:11]
   output logic      [shd_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_we,
   input  wire logic [shd_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [shd_pkg::CFG_BITS-1:0]      csr_wdata
);
   import shd_pkg::*;

   // configuration registers
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_period <= RST_DEBOUNCE_PERIOD;
         cfg_ff.fast_delay      <= RST_FAST_DELAY;
         cfg_ff.slow_delay      <= RST_SLOW_DELAY;
         cfg_ff.backoff_steps   <= RST_BACKOFF_STEPS;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_DEBOUNCE_PERIOD: cfg_ff.debounce_period <= csr_wdata;
            CSR_FAST_DELAY:      cfg_ff.fast_delay      <= csr_wdata;
            CSR_SLOW_DELAY:      cfg_ff.slow_delay      <= csr_wdata;
            CSR_BACKOFF_STEPS:   cfg_ff.backoff_steps   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   logic                     in_valid_ff;
   logic [REQ_DATA_BITS-1:0] in_data_ff;
   logic                     advance;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;

   // the tick in the input register moves on when the result slot frees up
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
      end
   end

   // field unpacking
   logic [RAW_BITS-1:0]  raw_switches;
   logic                 start_req;
   logic [AXIS_BITS-1:0] axis;
   logic                 home_dir;

   assign raw_switches = in_data_ff[2:0];
   assign start_req    = in_data_ff[3];
   assign axis         = in_data_ff[5:4];
   assign home_dir     = in_data_ff[6];

   // debounce runs first so the sequencer sees this tick's switch states
   logic [NUM_SWITCHES-1:0] switch_now;

   shd_debounce #(
      .HISTORY_BITS (HISTORY_BITS),
      .NUM_SWITCHES (NUM_SWITCHES)
   ) u_debounce (
      .clock           (clock),
      .reset           (reset),
      .tick            (advance),
      .raw_switches    (raw_switches),
      .debounce_period (cfg_ff.debounce_period),
      .switch_now      (switch_now)
   );

   seq_out_type seq_out;

   shd_sequencer #(
      .NUM_SWITCHES (NUM_SWITCHES)
   ) u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .tick       (advance),
      .start_req  (start_req),
      .axis       (axis),
      .home_dir   (home_dir),
      .switch_now (switch_now),
      .cfg        (cfg_ff),
      .result     (seq_out)
   );

   // switch_states shows the first three switches, absent ones read low
   logic [RAW_BITS-1:0] switch_states;

   for (genvar g = 0; g < RAW_BITS; g++) begin : g_states
      if (g < NUM_SWITCHES) begin : g_on
         assign switch_states[g] = switch_now[g];
      end else begin : g_off
         assign switch_states[g] = 1'b0;
      end
   end

   // result register
   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {5'b0, switch_states, seq_out.home_done, seq_out.phase,
                         seq_out.active_axis, seq_out.driver_enable,
                         seq_out.direction, seq_out.step_pulse};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

/* hdl/shd_debounce.sv */
`default_nettype none

module shd_debounce #(
   parameter int HISTORY_BITS = shd_pkg::DEF_HISTORY_BITS,
   parameter int NUM_SWITCHES = shd_pkg::DEF_NUM_SWITCHES
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          tick,
   input  wire logic [shd_pkg::RAW_BITS-1:0]  raw_switches,
   input  wire logic [shd_pkg::CFG_BITS-1:0]  debounce_period,
   output logic      [NUM_SWITCHES-1:0]       switch_now
);
   import shd_pkg::*;

   logic [CFG_BITS-1:0]     divider_ff, divider_in, divider_inc;
   logic                    sample;
   logic [NUM_SWITCHES-1:0] raw_bit;
   logic [HISTORY_BITS-1:0] history_ff [NUM_SWITCHES];
   logic [HISTORY_BITS-1:0] history_in [NUM_SWITCHES];
   logic [NUM_SWITCHES-1:0] debounced_ff, debounced_in;

   // switches past the raw field read as low
   for (genvar g = 0; g < NUM_SWITCHES; g++) begin : g_raw
      if (g < RAW_BITS) begin : g_on
         assign raw_bit[g] = raw_switches[g];
      end else begin : g_off
         assign raw_bit[g] = 1'b0;
      end
   end

   always_comb begin
      divider_inc = divider_ff + 1'b1;
      sample      = (divider_inc >= debounce_period);
      divider_in  = sample ? '0 : divider_inc;
      for (int i = 0; i < NUM_SWITCHES; i++) begin
         history_in[i] = sample ? {history_ff[i][HISTORY_BITS-2:0], raw_bit[i]}
                                : history_ff[i];
         if (history_in[i] == '1) begin
            debounced_in[i] = 1'b1;
         end else if (history_in[i] == '0) begin
            debounced_in[i] = 1'b0;
         end else begin
            debounced_in[i] = debounced_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff   <= '0;
         debounced_ff <= '0;
         for (int i = 0; i < NUM_SWITCHES; i++) begin
            history_ff[i] <= '0;
         end
      end else if (tick) begin
         divider_ff   <= divider_in;
         debounced_ff <= debounced_in;
         for (int i = 0; i < NUM_SWITCHES; i++) begin
            history_ff[i] <= history_in[i];
         end
      end
   end

   // state after this tick, seen by the sequencer in the same tick
   assign switch_now = debounced_in;

endmodule

`default_nettype wire

/* hdl/shd_sequencer.sv */
`default_nettype none

`include "assert_macros.svh"

module shd_sequencer #(
   parameter int NUM_SWITCHES = shd_pkg::DEF_NUM_SWITCHES
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          tick,
   input  wire logic                          start_req,
   input  wire logic [shd_pkg::AXIS_BITS-1:0] axis,
   input  wire logic                          home_dir,
   input  wire logic [NUM_SWITCHES-1:0]       switch_now,
   input  wire shd_pkg::cfg_type              cfg,
   output shd_pkg::seq_out_type               result
);
   import shd_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [CFG_BITS-1:0]  interval_ff, interval_in;
   logic [CFG_BITS-1:0]  backoff_ff, backoff_in;
   logic [AXIS_BITS-1:0] axis_ff, axis_in;
   logic                 saved_dir_ff, saved_dir_in;
   logic                 drive_dir_ff, drive_dir_in;

   logic [AXIS_SLOTS-1:0] switch_slot;
   logic                  switch_on;
   logic                  start_ok;
   logic                  backoff_over;
   logic [CFG_BITS-1:0]   delay;
   logic                  pace_step;
   logic [CFG_BITS-1:0]   pace_reload;
   logic                  step;
   logic                  done;

   for (genvar g = 0; g < AXIS_SLOTS; g++) begin : g_slot
      if (g < NUM_SWITCHES) begin : g_on
         assign switch_slot[g] = switch_now[g];
      end else begin : g_off
         assign switch_slot[g] = 1'b0;
      end
   end

   assign switch_on    = switch_slot[axis_ff];
   assign start_ok     = start_req && (int'(axis) < NUM_SWITCHES);
   assign backoff_over = (backoff_ff >= cfg.backoff_steps);
   assign delay        = (phase_ff == PH_CREEP) ? cfg.slow_delay : cfg.fast_delay;
   assign pace_step    = (interval_ff == '0);
   assign pace_reload  = (delay == '0) ? '0 : delay - 1'b1;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE:    if (start_ok)     phase_in = PH_FAST;
         PH_FAST:    if (switch_on)    phase_in = PH_BACKOFF;
         PH_BACKOFF: if (backoff_over) phase_in = PH_CREEP;
         PH_CREEP:   if (switch_on)    phase_in = PH_IDLE;
         default:                      phase_in = PH_IDLE;
      endcase
   end

   // counters, direction and step
   always_comb begin
      interval_in  = interval_ff;
      backoff_in   = backoff_ff;
      axis_in      = axis_ff;
      saved_dir_in = saved_dir_ff;
      drive_dir_in = drive_dir_ff;
      step         = 1'b0;
      done         = 1'b0;
      unique case (phase_ff) inside
         PH_IDLE: begin
            if (start_ok) begin
               axis_in      = axis;
               saved_dir_in = home_dir;
               drive_dir_in = home_dir;
               interval_in  = '0;
            end
         end
         PH_FAST, PH_CREEP: begin
            if (switch_on) begin
               interval_in = '0;
               if (phase_ff == PH_FAST) begin
                  drive_dir_in = ~saved_dir_ff;
                  backoff_in   = '0;
               end else begin
                  done = 1'b1;
               end
            end else begin
               step        = pace_step;
               interval_in = pace_step ? pace_reload : interval_ff - 1'b1;
            end
         end
         PH_BACKOFF: begin
            if (backoff_over) begin
               drive_dir_in = saved_dir_ff;
               interval_in  = '0;
            end else begin
               step        = pace_step;
               interval_in = pace_step ? pace_reload : interval_ff - 1'b1;
               if (pace_step) backoff_in = backoff_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         interval_ff  <= '0;
         backoff_ff   <= '0;
         axis_ff      <= '0;
         saved_dir_ff <= 1'b0;
         drive_dir_ff <= 1'b0;
      end else if (tick) begin
         phase_ff     <= phase_in;
         interval_ff  <= interval_in;
         backoff_ff   <= backoff_in;
         axis_ff      <= axis_in;
         saved_dir_ff <= saved_dir_in;
         drive_dir_ff <= drive_dir_in;
      end
   end

   always_comb begin
      result.step_pulse    = step;
      result.direction     = drive_dir_in;
      result.driver_enable = (phase_in != PH_IDLE);
      result.active_axis   = axis_in;
      result.phase         = phase_in;
      result.home_done     = done;
   end

   `SHD_ASSERT(a_step_only_busy, clock, reset, step |-> (phase_ff != PH_IDLE), "step while idle")
   `SHD_ASSERT(a_done_to_idle, clock, reset, (tick && done) |=> (phase_ff == PH_IDLE), "done without idle")
   `SHD_ASSERT(a_axis_in_range, clock, reset, (phase_ff != PH_IDLE) |-> (int'(axis_ff) < NUM_SWITCHES), "busy on bad axis")

endmodule

`default_nettype wire

/* test/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import shd_pkg::*;

   // expected view of one result item: sequencer fields in the low byte,
   // debounced switch levels above them, same order as rsp_tdata
   typedef struct packed {
      logic [DEF_NUM_SWITCHES-1:0] switch_states;
      seq_out_type                 seq;
   } tick_result_type;

   // tracks the homing sequencer and the switch debounce tick by tick and
   // holds the results still owed by the block
   class homing_scoreboard;
      logic [CFG_BITS-1:0]         debounce_period;
      logic [CFG_BITS-1:0]         fast_delay;
      logic [CFG_BITS-1:0]         slow_delay;
      logic [CFG_BITS-1:0]         backoff_steps;
      logic [DEF_HISTORY_BITS-1:0] switch_hist [DEF_NUM_SWITCHES];
      logic [DEF_NUM_SWITCHES-1:0] switch_on;
      logic [CFG_BITS-1:0]         sample_tick;
      logic [CFG_BITS-1:0]         step_timer;
      logic [CFG_BITS-1:0]         retreat_count;
      phase_type                   stage;
      logic [AXIS_BITS-1:0]        axis_q;
      logic                        toward_dir;
      logic                        drive_dir;
      tick_result_type             owed_results [$];
      int                          results_seen;
      int                          error_count;

      function new();
         debounce_period = RST_DEBOUNCE_PERIOD;
         fast_delay      = RST_FAST_DELAY;
         slow_delay      = RST_SLOW_DELAY;
         backoff_steps   = RST_BACKOFF_STEPS;
         foreach (switch_hist[i]) switch_hist[i] = '0;
         switch_on     = '0;
         sample_tick   = '0;
         step_timer    = '0;
         retreat_count = '0;
         stage         = PH_IDLE;
         axis_q        = '0;
         toward_dir    = 1'b0;
         drive_dir     = 1'b0;
         results_seen  = 0;
         error_count   = 0;
      endfunction

      function void set_register(logic [CSR_ADDR_BITS-1:0] addr, logic [CFG_BITS-1:0] value);
         case (addr)
            CSR_DEBOUNCE_PERIOD: debounce_period = value;
            CSR_FAST_DELAY:      fast_delay      = value;
            CSR_SLOW_DELAY:      slow_delay      = value;
            CSR_BACKOFF_STEPS:   backoff_steps   = value;
            default: ;
         endcase
      endfunction

      // step when the timer has run out, then reload; zero delay steps every tick
      function logic pace(logic [CFG_BITS-1:0] delay);
         if (step_timer != '0) begin
            step_timer = step_timer - 1'b1;
            return 1'b0;
         end
         step_timer = (delay == '0) ? '0 : delay - 1'b1;
         return 1'b1;
      endfunction

      function tick_result_type note_tick(logic [REQ_DATA_BITS-1:0] word);
         logic [RAW_BITS-1:0]  raw;
         logic                 start;
         logic [AXIS_BITS-1:0] ax;
         logic                 dir;
         logic                 step;
         logic                 done;
         logic                 at_switch;
         tick_result_type      outcome;
         raw   = word[2:0];
         start = word[3];
         ax    = word[5:4];
         dir   = word[6];
         step  = 1'b0;
         done  = 1'b0;

         // debounce first, the sequencer sees the new levels
         sample_tick = sample_tick + 1'b1;
         if (sample_tick >= debounce_period) begin
            sample_tick = '0;
            for (int i = 0; i < DEF_NUM_SWITCHES; i++) begin
               switch_hist[i] = {switch_hist[i][DEF_HISTORY_BITS-2:0], raw[i]};
               if (&switch_hist[i])
                  switch_on[i] = 1'b1;
               else if (switch_hist[i] == '0)
                  switch_on[i] = 1'b0;
            end
         end

         at_switch = (axis_q < DEF_NUM_SWITCHES) && switch_on[axis_q];

         case (stage)
            PH_IDLE: begin
               if (start && ax < DEF_NUM_SWITCHES) begin
                  axis_q     = ax;
                  toward_dir = dir;
                  drive_dir  = dir;
                  step_timer = '0;
                  stage      = PH_FAST;
               end
            end
            PH_FAST: begin
               if (at_switch) begin
                  drive_dir     = ~toward_dir;
                  retreat_count = '0;
                  step_timer    = '0;
                  stage         = PH_BACKOFF;
               end else begin
                  step = pace(fast_delay);
               end
            end
            PH_BACKOFF: begin
               if (retreat_count >= backoff_steps) begin
                  drive_dir  = toward_dir;
                  step_timer = '0;
                  stage      = PH_CREEP;
               end else if (pace(fast_delay)) begin
                  step          = 1'b1;
                  retreat_count = retreat_count + 1'b1;
               end
            end
            default: begin
               if (at_switch) begin
                  stage = PH_IDLE;
                  done  = 1'b1;
               end else begin
                  step = pace(slow_delay);
               end
            end
         endcase

         outcome.seq.step_pulse    = step;
         outcome.seq.direction     = drive_dir;
         outcome.seq.driver_enable = (stage != PH_IDLE);
         outcome.seq.active_axis   = axis_q;
         outcome.seq.phase         = stage;
         outcome.seq.home_done     = done;
         outcome.switch_states     = switch_on;
         owed_results.push_back(outcome);
         return outcome;
      endfunction

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         error_count++;
      endtask

      task compare_field(string name, logic [3:0] got, logic [3:0] want);
         if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                      results_seen, name, got, want));
      endtask

      task check_result(logic [RSP_DATA_BITS-1:0] word);
         tick_result_type got;
         tick_result_type want;
         got = word[$bits(tick_result_type)-1:0];
         results_seen++;
         if (owed_results.size() == 0) begin
            report_mismatch($sformatf("result %0d with no tick pending", results_seen));
            return;
         end
         want = owed_results.pop_front();
         compare_field("step_pulse", got.seq.step_pulse, want.seq.step_pulse);
         compare_field("direction", got.seq.direction, want.seq.direction);
         compare_field("driver_enable", got.seq.driver_enable, want.seq.driver_enable);
         compare_field("active_axis", got.seq.active_axis, want.seq.active_axis);
         compare_field("phase", got.seq.phase, want.seq.phase);
         compare_field("home_done", got.seq.home_done, want.seq.home_done);
         compare_field("switch_states", got.switch_states, want.switch_states);
      endtask
   endclass

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic                     csr_we     = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr   = CSR_DEBOUNCE_PERIOD;
   logic [CFG_BITS-1:0]      csr_wdata  = '0;

   homing_scoreboard sb;

   // idling knobs, changed only between phases
   int send_idle_pct = 0;
   int stall_pct     = 0;

   // one long receiver hold-off, asked for once by the stimulus
   bit hold_request = 1'b0;
   bit hold_used    = 1'b0;
   int hold_left    = 0;

   // simple plant: each switch closes once its axis has moved far enough
   int switch_pos [DEF_NUM_SWITCHES];

   always #1 clock = ~clock;

   stepper_homing_with_switch_debounce_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // receiver: random stalls, plus the long hold-off that backs the block up
   always @(posedge clock) begin
      if (hold_request && !hold_used) begin
         hold_used = 1'b1;
         hold_left = 80;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // result monitor, values seen here are the ones taken at this edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata);
   end

   function automatic logic [REQ_DATA_BITS-1:0] pack_tick(logic [RAW_BITS-1:0] raw,
                                                          logic start,
                                                          logic [AXIS_BITS-1:0] ax,
                                                          logic dir);
      return {1'b0, dir, ax, start, raw};
   endfunction

   // offer one item after an optional gap, wait for it to be taken
   task automatic send_tick(input logic [REQ_DATA_BITS-1:0] word,
                            output tick_result_type outcome);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= word;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      outcome = sb.note_tick(word);
   endtask

   task automatic send_repeat(input logic [REQ_DATA_BITS-1:0] word, input int count);
      tick_result_type outcome;
      repeat (count) send_tick(word, outcome);
   endtask

   // stop offering and let every owed result come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.owed_results.size() != 0);
   endtask

   // all four registers on back-to-back edges, only while nothing is in flight
   task automatic write_config(input cfg_type setting);
      logic [CSR_ADDR_BITS-1:0] addrs [4] = '{CSR_DEBOUNCE_PERIOD, CSR_FAST_DELAY,
                                             CSR_SLOW_DELAY, CSR_BACKOFF_STEPS};
      logic [CFG_BITS-1:0]      vals  [4];
      vals[0] = setting.debounce_period;
      vals[1] = setting.fast_delay;
      vals[2] = setting.slow_delay;
      vals[3] = setting.backoff_steps;
      for (int k = 0; k < 4; k++) begin
         csr_we    <= 1'b1;
         csr_addr  <= addrs[k];
         csr_wdata <= vals[k];
         @(posedge clock);
         sb.set_register(addrs[k], vals[k]);
      end
      csr_we <= 1'b0;
   endtask

   // mostly complete homing runs driven by the plant, with stray starts,
   // out-of-range axes and switch bounce mixed in
   task automatic run_random(input int count);
      logic [RAW_BITS-1:0]  raw;
      logic                 start;
      logic [AXIS_BITS-1:0] ax;
      logic                 dir;
      tick_result_type      outcome;
      for (int k = 0; k < count; k++) begin
         ax  = AXIS_BITS'($urandom_range(3));
         dir = 1'($urandom_range(1));
         if (sb.stage == PH_IDLE) begin
            if ($urandom_range(99) < 70) begin
               // new homing run from a random distance, zero means already closed
               start = 1'b1;
               ax    = AXIS_BITS'($urandom_range(DEF_NUM_SWITCHES - 1));
               switch_pos[ax] = 0 - int'($urandom_range(12));
            end else begin
               start = 1'($urandom_range(1));
            end
         end else begin
            // a start while busy should be ignored
            start = ($urandom_range(99) < 5);
         end
         // nudge some axis now and then so other switches toggle too
         if ($urandom_range(99) < 2)
            switch_pos[$urandom_range(DEF_NUM_SWITCHES - 1)] = int'($urandom_range(6)) - 3;
         for (int i = 0; i < RAW_BITS; i++)
            raw[i] = (switch_pos[i] >= 0) ^ ($urandom_range(99) < 3);
         send_tick(pack_tick(raw, start, ax, dir), outcome);
         // move the plant with every predicted step
         if (outcome.seq.step_pulse) begin
            if (outcome.seq.phase == PH_BACKOFF)
               switch_pos[outcome.seq.active_axis]--;
            else
               switch_pos[outcome.seq.active_axis]++;
         end
      end
   endtask

   task automatic run_phase(input cfg_type setting, input int gap_pct, input int stall,
                            input int count, input bit long_hold);
      drain();
      write_config(setting);
      send_idle_pct = gap_pct;
      stall_pct    <= stall;
      hold_request <= long_hold;
      run_random(count);
   endtask

   initial begin
      sb = new();
      switch_pos = '{-6, -3, 2};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset register values: nothing samples yet, axis 3 start is dropped
      send_repeat(pack_tick(3'b000, 1'b0, 2'd0, 1'b0), 1);
      send_repeat(pack_tick(3'b111, 1'b1, 2'd3, 1'b1), 1);

      // zero period and delays behave as one, every tick
      drain();
      write_config(cfg_type'{16'd0, 16'd0, 16'd0, 16'd0});
      // fill the histories so all switches settle closed
      send_repeat(pack_tick(3'b111, 1'b0, 2'd0, 1'b0), 8);
      // start on a closed switch: approach ends at once, zero backoff skips,
      // creep finishes at once, second start while busy is dropped
      send_repeat(pack_tick(3'b111, 1'b1, 2'd0, 1'b1), 1);
      send_repeat(pack_tick(3'b111, 1'b1, 2'd2, 1'b0), 1);
      send_repeat(pack_tick(3'b111, 1'b0, 2'd0, 1'b0), 2);
      // open all switches again
      send_repeat(pack_tick(3'b000, 1'b0, 2'd0, 1'b0), 8);
      // open switch: fast approach steps on every tick
      send_repeat(pack_tick(3'b101, 1'b1, 2'd1, 1'b0), 1);
      send_repeat(pack_tick(3'b010, 1'b0, 2'd0, 1'b0), 1);
      send_repeat(pack_tick(3'b000, 1'b0, 2'd0, 1'b0), 1);

      // random phases across idling patterns and register settings
      run_phase(cfg_type'{16'd1, 16'd1, 16'd2, 16'd3}, 0, 0, 150, 1'b0);
      run_phase(cfg_type'{16'd2, 16'd2, 16'd5, 16'd12}, 54, 0, 150, 1'b0);
      run_phase(cfg_type'{16'd1, 16'd2, 16'd1, 16'd15}, 0, 54, 150, 1'b0);
      run_phase(cfg_type'{16'd3, 16'd1, 16'd4, 16'd20}, 35, 35, 150, 1'b1);
      // top of every register range
      run_phase(cfg_type'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 35, 35, 50, 1'b0);
      run_phase(cfg_type'{16'd1, 16'd1, 16'hFFFF, 16'd1}, 0, 0, 60, 1'b0);

      drain();
      // keep clocking to catch any stray result
      repeat (20) @(posedge clock);
      if (sb.error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end
endmodule
